// ----- hdl/utf8_line_validator_top_macros.svh -----
// Assertion macros shared by the UTF-8 line validator modules.
`ifndef UTF8_LINE_VALIDATOR_TOP_MACROS_SVH
`define UTF8_LINE_VALIDATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define ULV_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("utf8 line validator: check failed");
`define ULV_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("utf8 line validator: check failed");
`else
`define ULV_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ULV_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- hdl/ulv_pkg.sv -----
// Types and constants shared by the UTF-8 line validator modules.
`timescale 1ns / 1ps
package ulv_pkg;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       final_byte;
  } ulv_in_t;

  typedef struct packed {
    logic [4:0]  status;
    logic [15:0] offset;
    logic [15:0] code_points;
  } ulv_out_t;

  typedef enum logic [2:0] {
    KIND_ASCII,
    KIND_TAB,
    KIND_CONT,
    KIND_HIGH_FE,
    KIND_LEAD
  } ulv_kind_t;

  // A classified byte as it travels from the front end to the back end.
  typedef struct packed {
    logic [7:0] data;
    logic       final_flag;
    ulv_kind_t  kind;
    logic [2:0] extra;
  } ulv_cls_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } ulv_qstat_t;

  localparam int unsigned MaxLineBytes = 65535;
  localparam int unsigned QueueDepth   = 4;

  // Report status codes. The missing-byte codes are StMissBase plus the count
  // of missing bytes, the bad-byte codes StBadBase plus the continuation slot,
  // and the overlong codes StOverBase plus the continuation count.
  localparam logic [4:0] StEnd       = 5'd0;
  localparam logic [4:0] StTab       = 5'd1;
  localparam logic [4:0] StMissBase  = 5'd1;
  localparam logic [4:0] StBadBase   = 5'd6;
  localparam logic [4:0] StFive      = 5'd12;
  localparam logic [4:0] StSix       = 5'd13;
  localparam logic [4:0] StRange     = 5'd14;
  localparam logic [4:0] StSurrogate = 5'd15;
  localparam logic [4:0] StOverBase  = 5'd15;
  localparam logic [4:0] StOver2     = 5'd16;
  localparam logic [4:0] StOver3     = 5'd17;
  localparam logic [4:0] StOver4     = 5'd18;
  localparam logic [4:0] StOver5     = 5'd19;
  localparam logic [4:0] StOver6     = 5'd20;
  localparam logic [4:0] StStray     = 5'd21;
  localparam logic [4:0] StHighFe    = 5'd22;

endpackage

// ----- hdl/utf8_line_validator_top.sv -----
// Top level of the UTF-8 line validator.
`timescale 1ns / 1ps
// Usage:
// The block takes a text line one byte per request on the input channel
// (in_valid, in_stall, in_item). The request carries line_byte and final_byte,
// which marks the last byte of the line. For each line exactly one request is
// sent on the output channel (out_valid, out_stall, out_item): a status, an
// offset and the count of complete valid code points before the stop.
// The line stops at the first tab, the first UTF-8 error, or its final byte;
// bytes after a stop, up to the final byte, give no further request.
// Throughput is one byte per cycle while the receiver does not stall; the back
// end updates its line state as it pops each byte. A byte accepted into the
// queue is decoded when it reaches the queue head, and its result request is
// registered in the result register before it is presented on the output.
// A short queue (QUEUE_DEPTH entries) sits between the classifying front end
// and the decoding back end. When the receiver stalls, the result register
// holds its request, the back end stops draining the queue, and in_stall rises
// once the queue is full; no byte or result is lost.
// Reset (rst, synchronous, active high) empties the queue, drops any pending
// result and returns the line state to the start of a new line.
// Offsets and counts saturate at MAX_LINE_BYTES or 65535, whichever is less.
module utf8_line_validator_top #(
  parameter int unsigned MAX_LINE_BYTES = ulv_pkg::MaxLineBytes,
  parameter int unsigned QUEUE_DEPTH    = ulv_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  ulv_pkg::ulv_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output ulv_pkg::ulv_out_t out_item
);
  import ulv_pkg::*;

  ulv_cls_t   push_item;
  ulv_cls_t   head;
  ulv_qstat_t qstat;
  logic       push;
  logic       pop;

  // The front end classifies each byte and pushes it into the queue.
  ulv_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .qstat     (qstat),
    .push      (push),
    .push_item (push_item)
  );

  ulv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  // The back end pops one byte per cycle whenever its result register is free.
  ulv_back #(
    .MAX_LINE_BYTES (MAX_LINE_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_valid   (qstat.not_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ----- hdl/ulv_front.sv -----
// Front end: takes bytes and classifies them for the back end.
`timescale 1ns / 1ps
module ulv_front (
  input  logic              in_valid,
  output logic              in_stall,
  input  ulv_pkg::ulv_in_t  in_item,
  input  ulv_pkg::ulv_qstat_t qstat,
  output logic              push,
  output ulv_pkg::ulv_cls_t push_item
);
  import ulv_pkg::*;

  localparam logic [7:0] ByteTab  = 8'h09;
  localparam logic [7:0] ByteC0   = 8'hc0;
  localparam logic [7:0] ByteE0   = 8'he0;
  localparam logic [7:0] ByteF0   = 8'hf0;
  localparam logic [7:0] ByteF8   = 8'hf8;
  localparam logic [7:0] ByteFc   = 8'hfc;
  localparam logic [7:0] ByteFe   = 8'hfe;

  logic [7:0] b;

  assign b        = in_item.line_byte;
  assign in_stall = qstat.full;
  assign push     = in_valid && !qstat.full;

  always_comb begin
    push_item.data       = b;
    push_item.final_flag = in_item.final_byte;
    push_item.extra      = 3'd0;
    if (!b[7]) begin
      push_item.kind = (b == ByteTab) ? KIND_TAB : KIND_ASCII;
    end else if (b < ByteC0) begin
      push_item.kind = KIND_CONT;
    end else if (b >= ByteFe) begin
      push_item.kind = KIND_HIGH_FE;
    end else begin
      push_item.kind = KIND_LEAD;
      if (b < ByteE0) begin
        push_item.extra = 3'd1;
      end else if (b < ByteF0) begin
        push_item.extra = 3'd2;
      end else if (b < ByteF8) begin
        push_item.extra = 3'd3;
      end else if (b < ByteFc) begin
        push_item.extra = 3'd4;
      end else begin
        push_item.extra = 3'd5;
      end
    end
  end

endmodule

// ----- hdl/ulv_queue.sv -----
// Short queue of classified bytes between the front and back ends.
`timescale 1ns / 1ps
`include "utf8_line_validator_top_macros.svh"
module ulv_queue #(
  parameter int unsigned DEPTH = ulv_pkg::QueueDepth
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ulv_pkg::ulv_cls_t   push_item,
  input  logic                pop,
  output ulv_pkg::ulv_cls_t   head,
  output ulv_pkg::ulv_qstat_t qstat
);
  import ulv_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  ulv_cls_t        slots [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign head            = slots[rd_ptr];
  assign qstat.full      = (count == FullCnt);
  assign qstat.not_empty = (count != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
  end

  `ULV_ASSERT_IMPL(a_no_overflow, clk, rst, push, count != FullCnt || pop)
  `ULV_ASSERT_IMPL(a_no_underflow, clk, rst, pop, count != '0)
  `ULV_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= FullCnt)

endmodule

// ----- hdl/ulv_back.sv -----
// Back end: runs the per-line decoding state and holds the result register.
`timescale 1ns / 1ps
`include "utf8_line_validator_top_macros.svh"
module ulv_back #(
  parameter int unsigned MAX_LINE_BYTES = ulv_pkg::MaxLineBytes
) (
  input  logic               clk,
  input  logic               rst,
  input  ulv_pkg::ulv_cls_t  head,
  input  logic               q_valid,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output ulv_pkg::ulv_out_t  out_item
);
  import ulv_pkg::*;

  localparam logic [15:0] SatLimit =
    (MAX_LINE_BYTES > 65535) ? 16'hffff : 16'(MAX_LINE_BYTES);

  localparam logic [7:0] Mask3e = 8'h3e;
  localparam logic [7:0] LeadE0 = 8'he0;
  localparam logic [7:0] LeadEd = 8'hed;
  localparam logic [7:0] LeadF0 = 8'hf0;
  localparam logic [7:0] LeadF4 = 8'hf4;
  localparam logic [7:0] LeadF8 = 8'hf8;
  localparam logic [7:0] LeadFc = 8'hfc;
  localparam logic [7:0] SecA0  = 8'ha0;
  localparam logic [7:0] Sec8f  = 8'h8f;
  localparam logic [7:0] Mask20 = 8'h20;
  localparam logic [7:0] Mask30 = 8'h30;
  localparam logic [7:0] Mask38 = 8'h38;
  localparam logic [7:0] Mask3c = 8'h3c;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v >= SatLimit) ? SatLimit : v + 16'd1;
  endfunction

  // Range, overlong, surrogate and five/six-byte rules on a character with good continuations.
  function automatic logic [4:0] char_check(input logic [7:0] c, input logic [7:0] d,
                                            input logic [2:0] ab);
    logic [4:0] code;
    code = StEnd;
    unique case (ab)
      3'd1: begin
        if ((c & Mask3e) == 8'd0) code = StOver2;
      end
      3'd2: begin
        if (c == LeadE0 && (d & Mask20) == 8'd0) code = StOver3;
        else if (c == LeadEd && d >= SecA0) code = StSurrogate;
      end
      3'd3: begin
        if (c == LeadF0 && (d & Mask30) == 8'd0) code = StOver4;
        else if (c > LeadF4 || (c == LeadF4 && d > Sec8f)) code = StRange;
      end
      3'd4: begin
        code = (c == LeadF8 && (d & Mask38) == 8'd0) ? StOver5 : StFive;
      end
      default: begin
        code = (c == LeadFc && (d & Mask3c) == 8'd0) ? StOver6 : StSix;
      end
    endcase
    return code;
  endfunction

  logic [15:0] byte_position, byte_position_next;
  logic [15:0] point_count, point_count_next;
  logic [7:0]  lead_value, lead_value_next;
  logic [7:0]  second_value, second_value_next;
  logic [2:0]  extra_needed, extra_needed_next;
  logic [2:0]  extra_seen, extra_seen_next;
  logic [15:0] char_start, char_start_next;
  logic [4:0]  pending_error, pending_error_next;
  logic        error_held, error_held_next;
  logic        line_done, line_done_next;

  logic        report;
  logic        clear_all;
  logic [2:0]  seen_new;
  logic [4:0]  code;
  logic [15:0] pos_inc;
  ulv_out_t    rsp;

  assign pop = q_valid && (!out_valid || !out_stall);

  always_comb begin
    byte_position_next = byte_position;
    point_count_next   = point_count;
    lead_value_next    = lead_value;
    second_value_next  = second_value;
    extra_needed_next  = extra_needed;
    extra_seen_next    = extra_seen;
    char_start_next    = char_start;
    pending_error_next = pending_error;
    error_held_next    = error_held;
    line_done_next     = line_done;
    report             = 1'b0;
    clear_all          = 1'b0;
    seen_new           = extra_seen + 3'd1;
    code               = StEnd;
    pos_inc            = sat_inc(byte_position);
    rsp.status         = StEnd;
    rsp.offset         = byte_position;

    if (line_done) begin
      clear_all = head.final_flag;
    end else begin
      if (extra_needed == 3'd0) begin
        unique case (head.kind)
          KIND_ASCII: point_count_next = sat_inc(point_count);
          KIND_TAB: begin
            report     = 1'b1;
            rsp.status = StTab;
          end
          KIND_CONT: begin
            report     = 1'b1;
            rsp.status = StStray;
          end
          KIND_HIGH_FE: begin
            report     = 1'b1;
            rsp.status = StHighFe;
          end
          default: begin
            lead_value_next    = head.data;
            second_value_next  = 8'd0;
            char_start_next    = byte_position;
            extra_needed_next  = head.extra;
            extra_seen_next    = 3'd0;
            pending_error_next = StEnd;
            error_held_next    = 1'b0;
            if (head.final_flag) begin
              report     = 1'b1;
              rsp.status = StMissBase + {2'b00, head.extra};
            end
          end
        endcase
      end else begin
        // Inside a character every byte fills a slot, whatever it is.
        extra_seen_next = seen_new;
        if (head.kind != KIND_CONT && !error_held) begin
          pending_error_next = StBadBase + {2'b00, seen_new};
          error_held_next    = 1'b1;
        end
        if (seen_new == 3'd1) begin
          second_value_next = head.data;
        end
        if (seen_new >= extra_needed) begin
          code = error_held_next ? pending_error_next
                                 : char_check(lead_value, second_value_next, extra_needed);
          extra_needed_next = 3'd0;
          if (code != StEnd) begin
            report     = 1'b1;
            rsp.status = code;
            rsp.offset = char_start;
          end else begin
            point_count_next = sat_inc(point_count);
          end
        end else if (head.final_flag) begin
          report     = 1'b1;
          rsp.status = StMissBase + {2'b00, extra_needed - seen_new};
          rsp.offset = char_start;
        end
      end

      byte_position_next = pos_inc;

      if (!report && head.final_flag) begin
        report     = 1'b1;
        rsp.status = StEnd;
        rsp.offset = pos_inc;
      end
      if (report) begin
        if (head.final_flag) clear_all = 1'b1;
        else line_done_next = 1'b1;
      end
    end

    rsp.code_points = point_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (pop && clear_all)) begin
      byte_position <= '0;
      point_count   <= '0;
      lead_value    <= '0;
      second_value  <= '0;
      extra_needed  <= '0;
      extra_seen    <= '0;
      char_start    <= '0;
      pending_error <= '0;
      error_held    <= 1'b0;
      line_done     <= 1'b0;
    end else if (pop) begin
      byte_position <= byte_position_next;
      point_count   <= point_count_next;
      lead_value    <= lead_value_next;
      second_value  <= second_value_next;
      extra_needed  <= extra_needed_next;
      extra_seen    <= extra_seen_next;
      char_start    <= char_start_next;
      pending_error <= pending_error_next;
      error_held    <= error_held_next;
      line_done     <= line_done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && report) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && report) begin
      out_item <= rsp;
    end
  end

  `ULV_ASSERT_IMPL(a_seen_bound, clk, rst, extra_needed != 3'd0, extra_seen < extra_needed)
  `ULV_ASSERT_IMPL(a_pending_code, clk, rst, error_held, (pending_error > StBadBase) && (pending_error < StFive))
  `ULV_ASSERT_IMPL(a_done_closed, clk, rst, line_done, extra_needed == 3'd0)
  `ULV_ASSERT_NEXT(a_report_shown, clk, rst, pop && report, out_valid)

endmodule
